### src/sscol_pkg.sv
// Shared constants and codes for the swept sphere collision test.
`timescale 1ns / 1ps
`default_nettype none

package sscol_pkg;

  // Default width of one coordinate word (signed fixed point).
  localparam int COORD_BITS_DEF = 32;

  // Width of the verdict field.
  localparam int VERDICT_BITS = 3;

  // Outcome of one sphere pair test.
  typedef enum logic [VERDICT_BITS-1:0] {
    VERD_OVERLAP  = 3'd0,
    VERD_SEPARATE = 3'd1,
    VERD_BEYOND   = 3'd2,
    VERD_HIT      = 3'd3,
    VERD_MISS     = 3'd4
  } verdict_t;

endpackage

`default_nettype wire

### src/sscol_if.sv
// Valid/ready channel interfaces for sphere pairs and test results.
`timescale 1ns / 1ps
`default_nettype none

interface sscol_in_if import sscol_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rel_pos_x;
  logic signed [COORD_BITS-1:0] rel_pos_y;
  logic signed [COORD_BITS-1:0] rel_pos_z;
  logic signed [COORD_BITS-1:0] rel_vel_x;
  logic signed [COORD_BITS-1:0] rel_vel_y;
  logic signed [COORD_BITS-1:0] rel_vel_z;
  logic        [COORD_BITS-3:0] radius_a;
  logic        [COORD_BITS-3:0] radius_b;

  modport source (
    output valid, rel_pos_x, rel_pos_y, rel_pos_z,
    output rel_vel_x, rel_vel_y, rel_vel_z, radius_a, radius_b,
    input  ready
  );
  modport sink (
    input  valid, rel_pos_x, rel_pos_y, rel_pos_z,
    input  rel_vel_x, rel_vel_y, rel_vel_z, radius_a, radius_b,
    output ready
  );
endinterface

interface sscol_out_if import sscol_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [VERDICT_BITS-1:0] verdict;

  modport source (output valid, hit, verdict, input ready);
  modport sink (input valid, hit, verdict, output ready);
endinterface

`default_nettype wire

### src/sscol_dot.sv
// Three pipeline stages forming pp, pv and vv from one sphere pair.
`timescale 1ns / 1ps
`default_nettype none

module sscol_dot import sscol_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic [2:0]                   en,
  input  wire logic signed [COORD_BITS-1:0] pos_x,
  input  wire logic signed [COORD_BITS-1:0] pos_y,
  input  wire logic signed [COORD_BITS-1:0] pos_z,
  input  wire logic signed [COORD_BITS-1:0] vel_x,
  input  wire logic signed [COORD_BITS-1:0] vel_y,
  input  wire logic signed [COORD_BITS-1:0] vel_z,
  input  wire logic [COORD_BITS-3:0]        rad_a,
  input  wire logic [COORD_BITS-3:0]        rad_b,
  output logic signed [2*COORD_BITS:0]      pp_r,
  output logic signed [2*COORD_BITS:0]      pv_r,
  output logic signed [2*COORD_BITS:0]      vv_r
);

  localparam int W2 = 2 * COORD_BITS;

  // Stage one: registered operands and radius sum.
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r;
  logic [COORD_BITS-2:0]        rsum_r;

  // Stage two: products.
  logic signed [W2-1:0] pxx_r, pyy_r, pzz_r;
  logic signed [W2-1:0] pvx_r, pvy_r, pvz_r;
  logic signed [W2-1:0] vxx_r, vyy_r, vzz_r;
  logic [W2-3:0]        rr_r;

  logic signed [W2:0] pp_nxt, pv_nxt, vv_nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r   <= pos_x;
      py_r   <= pos_y;
      pz_r   <= pos_z;
      vx_r   <= vel_x;
      vy_r   <= vel_y;
      vz_r   <= vel_z;
      rsum_r <= {1'b0, rad_a} + {1'b0, rad_b};
    end
    if (en[1]) begin
      pxx_r <= W2'(px_r * px_r);
      pyy_r <= W2'(py_r * py_r);
      pzz_r <= W2'(pz_r * pz_r);
      pvx_r <= W2'(px_r * vx_r);
      pvy_r <= W2'(py_r * vy_r);
      pvz_r <= W2'(pz_r * vz_r);
      vxx_r <= W2'(vx_r * vx_r);
      vyy_r <= W2'(vy_r * vy_r);
      vzz_r <= W2'(vz_r * vz_r);
      rr_r  <= (W2-2)'(rsum_r * rsum_r);
    end
    if (en[2]) begin
      pp_r <= pp_nxt;
      pv_r <= pv_nxt;
      vv_r <= vv_nxt;
    end
  end

  always_comb begin
    pp_nxt = {pxx_r[W2-1], pxx_r} + {pyy_r[W2-1], pyy_r} + {pzz_r[W2-1], pzz_r}
           - $signed({3'b000, rr_r});
    pv_nxt = {pvx_r[W2-1], pvx_r} + {pvy_r[W2-1], pvy_r} + {pvz_r[W2-1], pvz_r};
    vv_nxt = {vxx_r[W2-1], vxx_r} + {vyy_r[W2-1], vyy_r} + {vzz_r[W2-1], vzz_r};
  end

endmodule

`default_nettype wire

### src/sscol_screen.sv
// Early decision stage: overlap, separation and beyond-frame screening.
`timescale 1ns / 1ps
`default_nettype none

module sscol_screen import sscol_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [2*COORD_BITS:0] pp,
  input  wire logic signed [2*COORD_BITS:0] pv,
  input  wire logic signed [2*COORD_BITS:0] vv,
  output logic                            early_r,
  output verdict_t                        early_verd_r,
  output logic [2*COORD_BITS-1:0]         ppm_r,
  output logic [2*COORD_BITS-1:0]         vvm_r,
  output logic [2*COORD_BITS-1:0]         pvm_r
);

  localparam int W2 = 2 * COORD_BITS;

  logic signed [W2+1:0] t1;
  logic signed [W2+2:0] t2;
  logic signed [W2:0]   pv_neg;
  logic                 early_nxt;
  verdict_t             verd_nxt;

  always_comb begin
    t1     = {pv[W2], pv} + {vv[W2], vv};
    t2     = {{2{vv[W2]}}, vv} + {{2{pp[W2]}}, pp} + {pv[W2], pv, 1'b0};
    pv_neg = -pv;
    early_nxt = 1'b1;
    verd_nxt  = VERD_OVERLAP;
    priority if (pp[W2]) begin
      verd_nxt = VERD_OVERLAP;
    end else if (!pv[W2]) begin
      verd_nxt = VERD_SEPARATE;
    end else if ((t1[W2+1] || (t1 == '0)) && !t2[W2+2]) begin
      verd_nxt = VERD_BEYOND;
    end else begin
      early_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      early_r      <= early_nxt;
      early_verd_r <= verd_nxt;
      // On the approach path pp >= 0, vv > 0 and pv < 0, so all fit in W2 bits.
      ppm_r        <= pp[W2-1:0];
      vvm_r        <= vv[W2-1:0];
      pvm_r        <= pv_neg[W2-1:0];
    end
  end

endmodule

`default_nettype wire

### src/sscol_wmul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps
`default_nettype none

module sscol_wmul import sscol_pkg::*; #(
  parameter int HALF_BITS = COORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic [1:0]             en,
  input  wire logic [2*HALF_BITS-1:0] a,
  input  wire logic [2*HALF_BITS-1:0] b,
  output logic [4*HALF_BITS-1:0]      prod_r
);

  localparam int H  = HALF_BITS;
  localparam int PW = 4 * HALF_BITS;

  logic [2*H-1:0] ll_r, lh_r, hl_r, hh_r;
  logic [PW-1:0]  prod_nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ll_r <= (2*H)'(a[H-1:0]   * b[H-1:0]);
      lh_r <= (2*H)'(a[H-1:0]   * b[2*H-1:H]);
      hl_r <= (2*H)'(a[2*H-1:H] * b[H-1:0]);
      hh_r <= (2*H)'(a[2*H-1:H] * b[2*H-1:H]);
    end
    if (en[1]) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    prod_nxt = PW'(ll_r) + (PW'(lh_r) << H) + (PW'(hl_r) << H) + (PW'(hh_r) << (2*H));
  end

endmodule

`default_nettype wire

### src/swept_sphere_collision_test_core.sv
// Top level of the swept sphere-sphere collision test pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction carries one sphere pair: the position and velocity of
// B relative to A in signed fixed point, and the two radii. Each produces
// exactly one result transaction holding a hit flag and a verdict code.
// The pipeline has seven register stages: operand capture, the nine dot
// product terms and the squared radius sum, the three sums pp, pv and vv, the
// early screening (overlap, separating, beyond frame), the partial products of
// pp*vv and pv*pv, their sums, and the final compare in the output register.
// One transaction is accepted every cycle unless a stall on the result channel has
// backed up to the input; the multiplier stages are fully pipelined, each of which
// takes a new operand set per clock while its stage is enabled.
// Every stage has its own valid bit and loads whenever its successor can
// take its contents, so a stall on the result channel backs up only as far as
// the pipeline is full and empty stages keep taking new pairs. Nothing is lost
// or repeated across a stall. A synchronous active-low reset clears all valid
// bits; the datapath registers are not reset.

module swept_sphere_collision_test_core import sscol_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sscol_in_if.sink    in_ch,
  sscol_out_if.source out_ch
);

  localparam int W2     = 2 * COORD_BITS;
  localparam int STAGES = 7;

  // Stage enables and valid bits; stage STAGES is the output register.
  logic [STAGES:1]   en;
  logic [STAGES-1:1] v_r;
  logic              out_valid_r;
  logic              out_hit_r;
  verdict_t          out_verd_r;

  // Datapath between the parts.
  logic signed [W2:0] pp, pv, vv;
  logic               s4_early;
  verdict_t           s4_verd;
  logic [W2-1:0]      ppm, vvm, pvm;
  logic [2*W2-1:0]    lhs, rhs;

  // Early decisions ride alongside the wide multipliers.
  logic     s5_early_r, s6_early_r;
  verdict_t s5_verd_r, s6_verd_r;
  verdict_t out_verd_nxt;

  // A stage may load when it is empty or when its successor loads too.
  always_comb begin
    en[STAGES] = !out_valid_r || out_ch.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int k = 2; k < STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
      if (en[STAGES]) begin
        out_valid_r <= v_r[STAGES-1];
      end
    end
  end

  sscol_dot #(.COORD_BITS(COORD_BITS)) u_dot (
    .clk   (clk),
    .en    (en[3:1]),
    .pos_x (in_ch.rel_pos_x),
    .pos_y (in_ch.rel_pos_y),
    .pos_z (in_ch.rel_pos_z),
    .vel_x (in_ch.rel_vel_x),
    .vel_y (in_ch.rel_vel_y),
    .vel_z (in_ch.rel_vel_z),
    .rad_a (in_ch.radius_a),
    .rad_b (in_ch.radius_b),
    .pp_r  (pp),
    .pv_r  (pv),
    .vv_r  (vv)
  );

  sscol_screen #(.COORD_BITS(COORD_BITS)) u_screen (
    .clk          (clk),
    .en           (en[4]),
    .pp           (pp),
    .pv           (pv),
    .vv           (vv),
    .early_r      (s4_early),
    .early_verd_r (s4_verd),
    .ppm_r        (ppm),
    .vvm_r        (vvm),
    .pvm_r        (pvm)
  );

  // The closest squared gap pp - pv*pv/vv is tested as pp*vv against pv*pv.
  sscol_wmul #(.HALF_BITS(COORD_BITS)) u_mul_lhs (
    .clk    (clk),
    .en     (en[6:5]),
    .a      (ppm),
    .b      (vvm),
    .prod_r (lhs)
  );

  sscol_wmul #(.HALF_BITS(COORD_BITS)) u_mul_rhs (
    .clk    (clk),
    .en     (en[6:5]),
    .a      (pvm),
    .b      (pvm),
    .prod_r (rhs)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_early_r <= s4_early;
      s5_verd_r  <= s4_verd;
    end
    if (en[6]) begin
      s6_early_r <= s5_early_r;
      s6_verd_r  <= s5_verd_r;
    end
    if (en[STAGES]) begin
      out_verd_r <= out_verd_nxt;
      out_hit_r  <= (out_verd_nxt == VERD_OVERLAP) || (out_verd_nxt == VERD_HIT);
    end
  end

  // A closest gap of exactly zero counts as contact.
  always_comb begin
    if (s6_early_r) begin
      out_verd_nxt = s6_verd_r;
    end else if (lhs > rhs) begin
      out_verd_nxt = VERD_MISS;
    end else begin
      out_verd_nxt = VERD_HIT;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.hit     = out_hit_r;
  assign out_ch.verdict = out_verd_r;

endmodule

`default_nettype wire

### verif/sscol_verdict_monitor.sv
// Checker that predicts the hit flag and verdict of every sphere pair and compares results.
`timescale 1ns / 1ps

module sscol_verdict_monitor import sscol_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sscol_in_if              in_mon,
  sscol_out_if             out_mon,
  output int               fail_count,
  output int               in_flight,
  output int               results_seen,
  output logic [4:0][31:0] verdict_tally
);

  typedef struct packed {
    logic     hit;
    verdict_t verdict;
  } outcome_t;

  // Outcomes of accepted pairs, oldest first, waiting for their result transaction.
  outcome_t verdicts_due[$];
  outcome_t due;

  // Exact swept test. Every quantity carries the same scale, so the raw words are used
  // as integers; 132 bits hold every sum and product without loss.
  function automatic verdict_t judge_pair(
    input logic signed [31:0] px, py, pz, vx, vy, vz,
    input logic        [29:0] ra, rb
  );
    logic signed [131:0] p0, p1, p2, w0, w1, w2, rs;
    logic signed [131:0] pp, pv, vv, t1, t2, lhs, rhs;
    p0 = px;
    p1 = py;
    p2 = pz;
    w0 = vx;
    w1 = vy;
    w2 = vz;
    rs = ra;
    rs = rs + rb;
    pp = p0 * p0 + p1 * p1 + p2 * p2 - rs * rs;
    if (pp < 0) return VERD_OVERLAP;
    pv = p0 * w0 + p1 * w1 + p2 * w2;
    if (pv >= 0) return VERD_SEPARATE;
    vv = w0 * w0 + w1 * w1 + w2 * w2;
    // Closest approach after the frame ends, and still apart at its end.
    t1 = pv + vv;
    t2 = vv + pv + pv + pp;
    if (t1 <= 0 && t2 >= 0) return VERD_BEYOND;
    // Squared gap at closest approach, scaled by vv (positive here).
    lhs = pp * vv;
    rhs = pv * pv;
    return (lhs > rhs) ? VERD_MISS : VERD_HIT;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch on result %0d: %s", $realtime, results_seen, msg);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      verdicts_due.delete();
      fail_count    = 0;
      in_flight     = 0;
      results_seen  = 0;
      verdict_tally = '0;
    end else begin
      // The result side is handled first; the pipeline latency means a pair accepted
      // on this edge can never be the one leaving on it.
      if (out_mon.valid && out_mon.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding (hit %b, verdict %0d)",
                                    out_mon.hit, out_mon.verdict));
        end else begin
          due       = verdicts_due.pop_front();
          in_flight = in_flight - 1;
          if (out_mon.hit !== due.hit)
            report_mismatch($sformatf("hit %b, predicted %b", out_mon.hit, due.hit));
          if (out_mon.verdict !== due.verdict)
            report_mismatch($sformatf("verdict %0d, predicted %0d", out_mon.verdict,
                                      due.verdict));
        end
        results_seen = results_seen + 1;
      end
      if (in_mon.valid && in_mon.ready) begin
        due.verdict = judge_pair(in_mon.rel_pos_x, in_mon.rel_pos_y, in_mon.rel_pos_z,
                                 in_mon.rel_vel_x, in_mon.rel_vel_y, in_mon.rel_vel_z,
                                 in_mon.radius_a, in_mon.radius_b);
        due.hit     = (due.verdict == VERD_OVERLAP) || (due.verdict == VERD_HIT);
        verdicts_due.push_back(due);
        in_flight = in_flight + 1;
        verdict_tally[due.verdict] = verdict_tally[due.verdict] + 1;
      end
    end
  end

endmodule

### verif/tb_swept_sphere_collision_test_core.sv
// Top-level testbench for the swept sphere collision test core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_swept_sphere_collision_test_core;
  import sscol_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_PAIRS   = 2000;
  localparam int PRESSURE_PAIRS = 40;
  // The receiver holds off this long so that the seven-stage pipeline fills completely.
  localparam int LONG_HOLD      = 80;
  // Idle time allowed after the last result has arrived.
  localparam int TAIL_CYCLES    = 24;
  // Far beyond the longest quiet spell of a correct run (the long hold-off).
  localparam int WATCHDOG_LIMIT = 1000;

  // One unit in Q16.16.
  localparam int Q     = 65536;
  localparam int C_MAX = 2147483647;
  localparam int C_MIN = -2147483647 - 1;
  localparam int R_MAX = 1073741823;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic        [29:0] ra, rb;
  } pair_t;

  logic clk;
  logic rst_n;

  int               fail_count;
  int               in_flight;
  int               results_seen;
  logic [4:0][31:0] verdict_tally;

  int    pairs_accepted;
  int    quiet_cycles;
  int    hold_ask;
  int    hold_served;
  pair_t directed_pairs[$];

  sscol_in_if #(.COORD_BITS(32)) in_ch ();
  sscol_out_if                   out_ch ();

  swept_sphere_collision_test_core #(.COORD_BITS(32)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sscol_verdict_monitor u_verdicts (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .in_flight     (in_flight),
    .results_seen  (results_seen),
    .verdict_tally (verdict_tally)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic pair_t mk_pair(input int px, py, pz, vx, vy, vz, input int ra, rb);
    pair_t pr;
    pr.px = px;
    pr.py = py;
    pr.pz = pz;
    pr.vx = vx;
    pr.vy = vy;
    pr.vz = vz;
    pr.ra = ra[29:0];
    pr.rb = rb[29:0];
    return pr;
  endfunction

  // A signed value whose magnitude is at most 2^s (s = 31 gives the whole word).
  function automatic logic signed [31:0] at_scale(input int s);
    return $signed($urandom) >>> (31 - s);
  endfunction

  // Most pairs share one magnitude for positions and radii, so overlaps, near misses and
  // grazing approaches are all common. Just over half of those aim the velocity back at the other
  // sphere, covering a random fraction of the gap, which is what reaches the beyond-frame
  // and approach cases. A minority are raw 32-bit noise to exercise every input bit.
  function automatic pair_t random_pair();
    pair_t pr;
    int    kind, s, sv, sn, sh;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      pr.px = $urandom;
      pr.py = $urandom;
      pr.pz = $urandom;
      pr.vx = $urandom;
      pr.vy = $urandom;
      pr.vz = $urandom;
      pr.ra = 30'($urandom);
      pr.rb = 30'($urandom);
    end else begin
      s     = $urandom_range(0, 30);
      pr.px = at_scale(s);
      pr.py = at_scale(s);
      pr.pz = at_scale(s);
      pr.ra = 30'($urandom >> (33 - s));
      pr.rb = 30'($urandom >> (33 - s));
      if (kind < 60) begin
        sh    = $urandom_range(0, 5);
        sn    = (s > 3) ? s - 3 : 0;
        pr.vx = -(pr.px >>> sh) + at_scale(sn);
        pr.vy = -(pr.py >>> sh) + at_scale(sn);
        pr.vz = -(pr.pz >>> sh) + at_scale(sn);
      end else begin
        sv    = s + $urandom_range(0, 8) - 4;
        sv    = (sv < 0) ? 0 : ((sv > 31) ? 31 : sv);
        pr.vx = at_scale(sv);
        pr.vy = at_scale(sv);
        pr.vz = at_scale(sv);
      end
    end
    return pr;
  endfunction

  // Presents one pair and returns at the edge where the transaction completes. The valid
  // is left high, so a following pair goes out on the very next cycle.
  task automatic offer(input pair_t pr);
    in_ch.valid     <= 1'b1;
    in_ch.rel_pos_x <= pr.px;
    in_ch.rel_pos_y <= pr.py;
    in_ch.rel_pos_z <= pr.pz;
    in_ch.rel_vel_x <= pr.vx;
    in_ch.rel_vel_y <= pr.vy;
    in_ch.rel_vel_z <= pr.vz;
    in_ch.radius_a  <= pr.ra;
    in_ch.radius_b  <= pr.rb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pairs_accepted = pairs_accepted + 1;
  endtask

  // Stops offering and waits until every outstanding pair has produced its result.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (in_flight == 0);
    @(posedge clk);
  endtask

  // Result-side flow control. The receiver moves through stretches of different
  // behaviour: always ready, coin-toss stalls, mostly ready, and a fixed one-in-four
  // stall pattern. When the stimulus asks for a long hold-off it drops ready for
  // the whole hold-off, counted here, whatever the stretch was doing.
  initial begin : result_sink
    int mode, stretch_left, tick;
    out_ch.ready <= 1'b0;
    hold_served  = 0;
    stretch_left = 0;
    tick         = 0;
    mode         = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_served != hold_ask) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served = hold_served + 1;
      end else begin
        if (stretch_left == 0) begin
          mode         = $urandom_range(0, 3);
          stretch_left = $urandom_range(8, 64);
        end
        stretch_left = stretch_left - 1;
        tick         = tick + 1;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ((tick % 4) != 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long: a hung
  // handshake or a result that never comes.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired: no transaction for %0d cycles, %0d results outstanding.",
               quiet_cycles, in_flight);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int burst, gap, issued;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.rel_pos_x <= '0;
    in_ch.rel_pos_y <= '0;
    in_ch.rel_pos_z <= '0;
    in_ch.rel_vel_x <= '0;
    in_ch.rel_vel_y <= '0;
    in_ch.rel_vel_z <= '0;
    in_ch.radius_a  <= '0;
    in_ch.radius_b  <= '0;
    pairs_accepted  = 0;
    hold_ask        = 0;

    // Directed pairs. Q16.16 values are written as multiples of Q; the radius sum is
    // 10.0 in most of them.
    // Everything zero: touching at the start with no motion, hence separating.
    directed_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    // Coincident centres with a radius sum of one least significant bit: overlap.
    directed_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0, 0, 1));
    // Field extremes, where the products reach their widest.
    directed_pairs.push_back(mk_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, R_MAX, R_MAX));
    directed_pairs.push_back(mk_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, 0));
    directed_pairs.push_back(mk_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX, R_MAX));
    directed_pairs.push_back(mk_pair(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 0, R_MAX));
    directed_pairs.push_back(mk_pair(0, 0, 0, C_MIN, C_MAX, C_MIN, R_MAX, R_MAX));
    // Touching at the start is not an overlap: approaching gives a hit,
    // receding or sliding tangentially gives separating.
    directed_pairs.push_back(mk_pair(10*Q, 0, 0, -Q, 0, 0, 4*Q, 6*Q));
    directed_pairs.push_back(mk_pair(10*Q, 0, 0, Q, 0, 0, 4*Q, 6*Q));
    directed_pairs.push_back(mk_pair(0, 10*Q, 0, 3*Q, 0, 0, 5*Q, 5*Q));
    // Apart with velocity perpendicular to the offset, and with no velocity at all.
    directed_pairs.push_back(mk_pair(100*Q, 0, 0, 0, 5*Q, 0, 4*Q, 6*Q));
    directed_pairs.push_back(mk_pair(-50*Q, 20*Q, 7*Q, 0, 0, 0, Q, Q));
    // Closing slowly: closest approach after the frame, still apart at its end.
    directed_pairs.push_back(mk_pair(100*Q, 0, 0, -Q, 0, 0, 4*Q, 6*Q));
    // Spheres exactly touching at the end of the frame: still beyond the frame.
    directed_pairs.push_back(mk_pair(100*Q, 0, 0, -90*Q, 0, 0, 4*Q, 6*Q));
    // Closest approach exactly at the end of the frame, already inside by then.
    directed_pairs.push_back(mk_pair(100*Q, 0, 0, -100*Q, 0, 0, 4*Q, 6*Q));
    // Head-on approach inside the frame, and the same with an offset that misses.
    directed_pairs.push_back(mk_pair(100*Q, 0, 0, -200*Q, 0, 0, 4*Q, 6*Q));
    directed_pairs.push_back(mk_pair(100*Q, 50*Q, 0, -200*Q, 0, 0, 4*Q, 6*Q));
    // Grazing contact: a closest gap of exactly zero is a hit; one bit wider misses,
    // one bit narrower hits.
    directed_pairs.push_back(mk_pair(5*Q, 10*Q, 0, -20*Q, 0, 0, 4*Q, 6*Q));
    directed_pairs.push_back(mk_pair(5*Q, 10*Q + 1, 0, -20*Q, 0, 0, 4*Q, 6*Q));
    directed_pairs.push_back(mk_pair(5*Q, 10*Q - 1, 0, -20*Q, 0, 0, 4*Q, 6*Q));
    // Approach from the negative octant.
    directed_pairs.push_back(mk_pair(-30*Q, -40*Q, 0, 60*Q, 80*Q, 0, 3*Q, 2*Q));
    // Alternating bit patterns in every field.
    directed_pairs.push_back(mk_pair(int'(32'hAAAAAAAA), int'(32'h55555555), int'(32'hAAAAAAAA),
                                     int'(32'h55555555), int'(32'hAAAAAAAA), int'(32'h55555555),
                                     int'(32'h2AAAAAAA), int'(32'h15555555)));
    directed_pairs.push_back(mk_pair(int'(32'h55555555), int'(32'hAAAAAAAA), int'(32'h55555555),
                                     int'(32'hAAAAAAAA), int'(32'h55555555), int'(32'hAAAAAAAA),
                                     int'(32'h15555555), int'(32'h2AAAAAAA)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_pairs[i]) offer(directed_pairs[i]);
    // The sender pauses here until every directed result has been checked.
    drain_results();

    // Back pressure: the receiver holds off while pairs keep coming back to back, so the
    // pipeline fills and the input must stall without losing or repeating a transaction.
    hold_ask = hold_ask + 1;
    repeat (PRESSURE_PAIRS) offer(random_pair());
    drain_results();

    // Random traffic in bursts. About a quarter of the bursts are followed directly by
    // the next one, giving long stretches with the input never idle.
    issued = 0;
    while (issued < RANDOM_PAIRS) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && issued < RANDOM_PAIRS) begin
        offer(random_pair());
        burst  = burst - 1;
        issued = issued + 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    drain_results();
    // Give the pipeline time to show any spurious extra result.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d sphere pairs (%0d directed, %0d under a full stall) and %0d results.",
             pairs_accepted, directed_pairs.size(), PRESSURE_PAIRS, results_seen);
    $display("Verdicts: overlap %0d, separating %0d, beyond frame %0d, hit %0d, miss %0d.",
             verdict_tally[VERD_OVERLAP], verdict_tally[VERD_SEPARATE],
             verdict_tally[VERD_BEYOND], verdict_tally[VERD_HIT], verdict_tally[VERD_MISS]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
